@@ rtl/core/uks_pkg.sv @@
// shared constants, types and character checks for the uuid keyed table scan
package uks_pkg;

    localparam int ENTRY_BYTES  = 38;
    localparam int SECTOR_BYTES = 4096;
    localparam int UUID_CHARS   = 36;

    localparam int POS_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 32;
    localparam int SECTOR_W  = 16;
    localparam int CFG_W     = 64;
    localparam int KEY_WORDS = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] CH_HYPHEN = 8'h2d;
    localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_4      = 8'h34;
    localparam logic [BYTE_W-1:0] CH_8      = 8'h38;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UA     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UB     = 8'h42;
    localparam logic [BYTE_W-1:0] CH_UF     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LA     = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LB     = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h66;

    localparam logic [POS_W-1:0] POS_HYPHEN0 = 6'd8;
    localparam logic [POS_W-1:0] POS_HYPHEN1 = 6'd13;
    localparam logic [POS_W-1:0] POS_VERSION = 6'd14;
    localparam logic [POS_W-1:0] POS_HYPHEN2 = 6'd18;
    localparam logic [POS_W-1:0] POS_VARIANT = 6'd19;
    localparam logic [POS_W-1:0] POS_HYPHEN3 = 6'd23;
    localparam logic [POS_W-1:0] POS_SEC_LO  = POS_W'(UUID_CHARS);
    localparam logic [POS_W-1:0] POS_SEC_HI  = POS_W'(UUID_CHARS + 1);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(ENTRY_BYTES - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0 = 3'd0,
        CFG_KEY1 = 3'd1,
        CFG_KEY2 = 3'd2,
        CFG_KEY3 = 3'd3,
        CFG_KEY4 = 3'd4,
        CFG_BASE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_WORDS-1:0][CFG_W-1:0] key_word;
        logic [ADDR_W-1:0]               base;
    } t_cfg;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic form_ok_at(input logic [POS_W-1:0] pos,
                                        input logic [BYTE_W-1:0] c);
        logic ok;
        priority if (pos == POS_HYPHEN0 || pos == POS_HYPHEN1 ||
                     pos == POS_HYPHEN2 || pos == POS_HYPHEN3) begin
            ok = (c == CH_HYPHEN);
        end else if (pos == POS_VERSION) begin
            ok = (c == CH_4);
        end else if (pos == POS_VARIANT) begin
            ok = (c == CH_8) || (c == CH_9) || (c == CH_UA) || (c == CH_UB) ||
                 (c == CH_LA) || (c == CH_LB);
        end else begin
            ok = is_hex(c);
        end
        return ok;
    endfunction

endpackage

@@ rtl/core/uks_in_if.sv @@
// input channel: one table byte per beat
interface uks_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] table_byte;
    logic       region_end;

    modport source (output valid, output table_byte, output region_end, input ready);
    modport sink   (input valid, input table_byte, input region_end, output ready);
endinterface

@@ rtl/core/uks_out_if.sv @@
// output channel: one lookup result per beat
interface uks_out_if;
    logic        valid;
    logic        ready;
    logic        lookup_status;
    logic [31:0] found_address;
    logic [15:0] found_sector;

    modport source (output valid, output lookup_status, output found_address,
                    output found_sector, input ready);
    modport sink   (input valid, input lookup_status, input found_address,
                    input found_sector, output ready);
endinterface

@@ rtl/core/uks_cfg_regs.sv @@
// key and base address registers behind the write port
module uks_cfg_regs
    import uks_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KEY0: begin
                    r_cfg.key_word[0] <= i_cfg_data;
                end
                CFG_KEY1: begin
                    r_cfg.key_word[1] <= i_cfg_data;
                end
                CFG_KEY2: begin
                    r_cfg.key_word[2] <= i_cfg_data;
                end
                CFG_KEY3: begin
                    r_cfg.key_word[3] <= i_cfg_data;
                end
                CFG_KEY4: begin
                    // only four key characters live in the last word
                    r_cfg.key_word[4] <= {{(CFG_W-ADDR_W){1'b0}}, i_cfg_data[ADDR_W-1:0]};
                end
                CFG_BASE: begin
                    r_cfg.base <= i_cfg_data[ADDR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/uks_scan_core.sv @@
// input register, per-byte scan state update and result register
module uks_scan_core
    import uks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    uks_in_if.sink      i_in,
    uks_out_if.source   o_out
);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    // scan state
    logic [POS_W-1:0]  r_pos,      n_pos;
    logic              r_key_eq,   n_key_eq;
    logic [BYTE_W-1:0] r_sec_lo,   n_sec_lo;
    logic [BYTE_W-1:0] r_sec_hi,   n_sec_hi;
    logic              r_decided,  n_decided;

    // result register
    logic                r_out_valid;
    logic                r_status;
    logic [ADDR_W-1:0]   r_addr;
    logic [SECTOR_W-1:0] r_sector;

    logic                advance;
    logic                emit;
    logic                emit_found;
    logic [CFG_W-1:0]    key_sel;
    logic [BYTE_W-1:0]   key_char;
    logic [SECTOR_W-1:0] sector;
    logic [ADDR_W-1:0]   n_addr;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_comb begin
        key_sel = '0;
        if (r_pos[POS_W-1:3] < 3'(KEY_WORDS)) begin
            key_sel = i_cfg.key_word[r_pos[POS_W-1:3]];
        end
    end
    assign key_char = key_sel[{r_pos[2:0], 3'b000} +: BYTE_W];

    always_comb begin
        n_pos      = r_pos;
        n_key_eq   = r_key_eq;
        n_sec_lo   = r_sec_lo;
        n_sec_hi   = r_sec_hi;
        n_decided  = r_decided;
        emit       = 1'b0;
        emit_found = 1'b0;
        sector     = '0;
        if (advance) begin
            if (!r_decided) begin
                if (r_pos == '0 && r_byte == '0) begin
                    // empty entry ends the table
                    emit      = 1'b1;
                    n_decided = 1'b1;
                end else if (r_pos < POS_SEC_LO) begin
                    n_key_eq = r_key_eq && (r_byte == key_char);
                    // a malformed uuid ends the scan at once
                    if (!form_ok_at(r_pos, r_byte)) begin
                        emit      = 1'b1;
                        n_decided = 1'b1;
                    end
                end else if (r_pos == POS_SEC_LO) begin
                    n_sec_lo = r_byte;
                end else if (r_pos == POS_SEC_HI) begin
                    n_sec_hi = r_byte;
                end

                if (!n_decided) begin
                    if (r_pos >= POS_LAST) begin
                        if (n_key_eq) begin
                            emit       = 1'b1;
                            emit_found = 1'b1;
                            n_decided  = 1'b1;
                            // taken before a region end clears the sector bytes
                            sector     = {n_sec_hi, n_sec_lo};
                        end else begin
                            n_pos    = '0;
                            n_key_eq = 1'b1;
                            n_sec_lo = '0;
                            n_sec_hi = '0;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end

                if (!n_decided && r_last) begin
                    emit      = 1'b1;
                    n_decided = 1'b1;
                end
            end

            // end of region rearms for the next scan
            if (r_last) begin
                n_pos     = '0;
                n_key_eq  = 1'b1;
                n_sec_lo  = '0;
                n_sec_hi  = '0;
                n_decided = 1'b0;
            end
        end
    end

    assign n_addr = i_cfg.base + ADDR_W'(ADDR_W'(sector) * ADDR_W'(SECTOR_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.table_byte;
            r_last <= i_in.region_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_key_eq  <= 1'b1;
            r_sec_lo  <= '0;
            r_sec_hi  <= '0;
            r_decided <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_key_eq  <= n_key_eq;
            r_sec_lo  <= n_sec_lo;
            r_sec_hi  <= n_sec_hi;
            r_decided <= n_decided;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_status <= !emit_found;
            r_addr   <= emit_found ? n_addr : '0;
            r_sector <= emit_found ? sector : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.lookup_status = r_status;
    assign o_out.found_address = r_addr;
    assign o_out.found_sector  = r_sector;

endmodule

@@ rtl/core/uuid_keyed_table_scan_top.sv @@
// Scans a lookup region one byte per beat for the entry whose text uuid equals the
// configured key, and returns base plus sector times sector size, or not found. It
// takes one byte every cycle; a stalled result register backs up into the one-byte input
// register, so input ready drops only while a result waits and a byte is already held.
// At most one result comes per region; the byte with region end set rearms the scan.
// Key and base registers are written through the plain write port; the user must write
// them only while no scan is in progress, and the block itself does not enforce it.
module uuid_keyed_table_scan_top
    import uks_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    uks_in_if.sink               i_in,
    uks_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg cfg;

    uks_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    uks_scan_core u_scan_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

@@ rtl/core/uks_checker.sv @@
// port-level checks for the uuid keyed table scan, bound to the top level
module uks_checker
    import uks_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_out_status,
    input logic [ADDR_W-1:0]   i_out_address,
    input logic [SECTOR_W-1:0] i_out_sector
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status) &&
        $stable(i_out_address) && $stable(i_out_sector))
        else $error("stalled result changed");

    // not found carries zero address and sector
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> i_out_address == '0 && i_out_sector == '0)
        else $error("not found result with nonzero payload");

    // with the result register empty, input is never held off
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while no result pending");

    // no result right out of reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind uuid_keyed_table_scan_top uks_checker u_uks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.lookup_status),
    .i_out_address (o_out.found_address),
    .i_out_sector  (o_out.found_sector)
);

@@ tb/tb.sv @@
// self-checking testbench for the uuid keyed table scan: lookup regions in, checked results out
`timescale 1ns / 1ps

module tb;
    import uks_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;
    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_MISS  = 1'b1;
    localparam int TARGET_BEATS   = 1200;
    localparam int TARGET_RESULTS = 40;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SETTLE_LIMIT   = 50000;
    localparam int PRINT_LIMIT    = 100;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_scan_beat;

    typedef struct packed {
        logic                status;
        logic [ADDR_W-1:0]   addr;
        logic [SECTOR_W-1:0] sector;
    } t_lookup_result;

    typedef enum int {
        RG_MATCH, RG_MISS, RG_CUT, RG_EMPTY, RG_BADFORM, RG_NEAR, RG_NOISE
    } t_region_kind;

    typedef enum int { KEY_UUID, KEY_ONES, KEY_ZERO, KEY_NOISE } t_key_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    uks_in_if  scan_in ();
    uks_out_if scan_out ();

    uuid_keyed_table_scan_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (scan_in),
        .o_out       (scan_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_scan_beat     beat_q[$];
    t_lookup_result lookup_expect_q[$];
    t_scan_beat     held_beat;
    bit             have_held;

    logic [BYTE_W-1:0] key_txt [UUID_CHARS];
    logic [BYTE_W-1:0] ent_txt [UUID_CHARS];

    // predictor copy of the registers and the scan state
    logic [CFG_W-1:0]  key_word [KEY_WORDS];
    logic [ADDR_W-1:0] area_base;
    logic [POS_W-1:0]  scan_pos;
    logic              uuid_ok;
    logic              key_match;
    logic [BYTE_W-1:0] sec_lo;
    logic [BYTE_W-1:0] sec_hi;
    logic              scan_done;

    int err_cnt;
    int beats_pushed;
    int beats_in;
    int results_out;
    int found_out;
    int regions_cnt;
    int settings_cnt;
    bit idle_on;
    int in_gap;
    int out_gap;

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic logic is_hyphen_pos(input int p);
        return p == POS_HYPHEN0 || p == POS_HYPHEN1 || p == POS_HYPHEN2 || p == POS_HYPHEN3;
    endfunction

    function automatic logic char_fits(input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] lc;
        logic              digit;
        lc = c | 8'h20;
        digit = (c >= CH_0) && (c <= CH_9);
        if (is_hyphen_pos(pos))
            return c == CH_HYPHEN;
        if (pos == POS_VERSION)
            return c == CH_4;
        if (pos == POS_VARIANT)
            return c == CH_8 || c == CH_9 || lc == CH_LA || lc == CH_LB;
        // folding case maps A-F onto a-f and nothing else into that range
        return digit || (lc >= CH_LA && lc <= CH_LF);
    endfunction

    function automatic logic [BYTE_W-1:0] key_at(input logic [POS_W-1:0] pos);
        return key_word[pos[5:3]][{pos[2:0], 3'b000} +: 8];
    endfunction

    task automatic push_result(input logic st, input logic [ADDR_W-1:0] a,
                               input logic [SECTOR_W-1:0] s);
        t_lookup_result r;
        r = '{status: st, addr: a, sector: s};
        lookup_expect_q.push_back(r);
    endtask

    task automatic restart_entry;
        scan_pos  = '0;
        uuid_ok   = 1'b1;
        key_match = 1'b1;
        sec_lo    = '0;
        sec_hi    = '0;
    endtask

    task automatic miss_now;
        push_result(STATUS_MISS, '0, '0);
        scan_done = 1'b1;
    endtask

    task automatic predict_lookup(input logic [BYTE_W-1:0] c, input logic last);
        logic [POS_W-1:0]    pos;
        logic [SECTOR_W-1:0] sec;
        logic [ADDR_W-1:0]   addr;
        if (!scan_done) begin
            pos = scan_pos;
            if (pos == 0 && c == 8'h00) begin
                miss_now();
            end else if (pos < UUID_CHARS) begin
                if (!char_fits(pos, c))
                    uuid_ok = 1'b0;
                if (c != key_at(pos))
                    key_match = 1'b0;
                if (!uuid_ok)
                    miss_now();
            end else if (pos == POS_SEC_LO) begin
                sec_lo = c;
            end else if (pos == POS_SEC_HI) begin
                sec_hi = c;
            end
            if (!scan_done) begin
                if (pos >= POS_LAST) begin
                    if (uuid_ok && key_match) begin
                        sec  = {sec_hi, sec_lo};
                        addr = area_base + ADDR_W'(sec) * ADDR_W'(SECTOR_BYTES);
                        push_result(STATUS_FOUND, addr, sec);
                        scan_done = 1'b1;
                    end else begin
                        restart_entry();
                    end
                end else begin
                    scan_pos = pos + 1'b1;
                end
            end
            if (!scan_done && last)
                miss_now();
        end
        // region end always rearms
        if (last) begin
            restart_entry();
            scan_done = 1'b0;
        end
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_KEY0: key_word[0] = data;
            CFG_KEY1: key_word[1] = data;
            CFG_KEY2: key_word[2] = data;
            CFG_KEY3: key_word[3] = data;
            CFG_KEY4: key_word[4] = {32'h0, data[31:0]};
            CFG_BASE: area_base   = data[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        apply_reg(idx, data);
    endtask

    function automatic logic [BYTE_W-1:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return CH_0 + 8'(v);
        if ($urandom_range(0, 1) != 0)
            return CH_UA + 8'(v - 10);
        return CH_LA + 8'(v - 10);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_variant();
        case ($urandom_range(0, 5))
            0: return CH_8;
            1: return CH_9;
            2: return CH_UA;
            3: return CH_UB;
            4: return CH_LA;
            default: return CH_LB;
        endcase
    endfunction

    function automatic logic [SECTOR_W-1:0] rand_sector();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return SECTOR_W'($urandom);
        endcase
    endfunction

    task automatic rand_uuid;
        int i;
        for (i = 0; i < UUID_CHARS; i++) begin
            if (is_hyphen_pos(i))
                ent_txt[i] = CH_HYPHEN;
            else if (i == POS_VERSION)
                ent_txt[i] = CH_4;
            else if (i == POS_VARIANT)
                ent_txt[i] = rand_variant();
            else
                ent_txt[i] = rand_hex();
        end
    endtask

    task automatic load_key_entry;
        int i;
        for (i = 0; i < UUID_CHARS; i++)
            ent_txt[i] = key_txt[i];
    endtask

    task automatic make_key(input t_key_kind kind);
        int i;
        rand_uuid();
        for (i = 0; i < UUID_CHARS; i++) begin
            case (kind)
                KEY_ONES:  key_txt[i] = 8'hff;
                KEY_ZERO:  key_txt[i] = 8'h00;
                KEY_NOISE: key_txt[i] = BYTE_W'($urandom);
                default:   key_txt[i] = ent_txt[i];
            endcase
        end
    endtask

    // only called while the scan is idle
    task automatic set_config(input logic [ADDR_W-1:0] base);
        logic [CFG_W-1:0] w [KEY_WORDS];
        int               i;
        for (i = 0; i < KEY_WORDS; i++)
            w[i] = '0;
        for (i = 0; i < UUID_CHARS; i++)
            w[i / 8][(i % 8) * 8 +: 8] = key_txt[i];
        // upper half of the last key word must be dropped
        w[4][63:32] = $urandom;
        write_reg(CFG_KEY0, w[0]);
        write_reg(CFG_KEY1, w[1]);
        write_reg(CFG_KEY2, w[2]);
        write_reg(CFG_KEY3, w[3]);
        write_reg(CFG_KEY4, w[4]);
        write_reg(CFG_BASE, {$urandom, base});
        write_reg(CFG_SPARE6, {$urandom, $urandom});
        write_reg(CFG_SPARE7, {$urandom, $urandom});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] b);
        if (have_held) begin
            beat_q.push_back(held_beat);
            beats_pushed++;
        end
        held_beat = '{data: b, last: 1'b0};
        have_held = 1'b1;
    endtask

    task automatic close_region;
        held_beat.last = 1'b1;
        beat_q.push_back(held_beat);
        beats_pushed++;
        have_held = 1'b0;
        regions_cnt++;
    endtask

    function automatic logic [BYTE_W-1:0] entry_byte(input int j, input logic [SECTOR_W-1:0] sec);
        if (j < UUID_CHARS)
            return ent_txt[j];
        if (j == UUID_CHARS)
            return sec[7:0];
        if (j == UUID_CHARS + 1)
            return sec[15:8];
        return BYTE_W'($urandom);
    endfunction

    task automatic put_partial(input int k, input logic [SECTOR_W-1:0] sec);
        int j;
        for (j = 0; j < k; j++)
            put_byte(entry_byte(j, sec));
    endtask

    task automatic put_others(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            rand_uuid();
            put_partial(ENTRY_BYTES, rand_sector());
        end
    endtask

    task automatic put_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            put_byte(BYTE_W'($urandom));
    endtask

    task automatic gen_region(input t_region_kind kind);
        int                p;
        logic [BYTE_W-1:0] old;
        case (kind)
            RG_MATCH: begin
                put_others($urandom_range(0, 2));
                load_key_entry();
                put_partial(ENTRY_BYTES, rand_sector());
                put_noise($urandom_range(0, 4));
            end
            RG_MISS: begin
                put_others($urandom_range(1, 2));
            end
            RG_CUT: begin
                put_others($urandom_range(0, 1));
                if ($urandom_range(0, 1) != 0)
                    load_key_entry();
                else
                    rand_uuid();
                put_partial($urandom_range(1, ENTRY_BYTES - 1), rand_sector());
            end
            RG_EMPTY: begin
                put_others($urandom_range(0, 2));
                put_byte(8'h00);
                put_noise($urandom_range(0, 3));
            end
            RG_BADFORM: begin
                put_others($urandom_range(0, 1));
                if ($urandom_range(0, 1) != 0)
                    load_key_entry();
                else
                    rand_uuid();
                ent_txt[$urandom_range(0, UUID_CHARS - 1)] = BYTE_W'($urandom);
                put_partial(ENTRY_BYTES, rand_sector());
                put_noise($urandom_range(0, 3));
            end
            RG_NEAR: begin
                // key with one free character swapped for another legal one
                load_key_entry();
                do begin
                    p = $urandom_range(0, UUID_CHARS - 1);
                end while (is_hyphen_pos(p) || p == POS_VERSION);
                old = ent_txt[p];
                do begin
                    ent_txt[p] = (p == POS_VARIANT) ? rand_variant() : rand_hex();
                end while (ent_txt[p] == old);
                put_partial(ENTRY_BYTES, rand_sector());
                if ($urandom_range(0, 1) != 0) begin
                    load_key_entry();
                    put_partial(ENTRY_BYTES, rand_sector());
                end
            end
            default: begin
                put_noise($urandom_range(1, 40));
            end
        endcase
        close_region();
    endtask

    function automatic t_region_kind pick_kind();
        int r;
        r = $urandom_range(0, 15);
        if (r < 5)  return RG_MATCH;
        if (r < 7)  return RG_MISS;
        if (r < 9)  return RG_CUT;
        if (r < 11) return RG_EMPTY;
        if (r < 13) return RG_BADFORM;
        if (r < 15) return RG_NEAR;
        return RG_NOISE;
    endfunction

    task automatic settle;
        int guard;
        guard = 0;
        while ((beats_in != beats_pushed || lookup_expect_q.size() != 0) && guard < SETTLE_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_beats
        t_scan_beat nxt;
        if (!i_rst_n) begin
            scan_in.valid      <= 1'b0;
            scan_in.table_byte <= '0;
            scan_in.region_end <= 1'b0;
            in_gap = 0;
        end else begin
            if (scan_in.valid && scan_in.ready) begin
                predict_lookup(scan_in.table_byte, scan_in.region_end);
                beats_in++;
            end
            // a beat on the bus is held until taken
            if (!scan_in.valid || scan_in.ready) begin
                if (in_gap != 0) begin
                    in_gap--;
                    scan_in.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 15) == 0) begin
                    in_gap = $urandom_range(0, 7);
                    scan_in.valid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    nxt = beat_q.pop_front();
                    scan_in.valid      <= 1'b1;
                    scan_in.table_byte <= nxt.data;
                    scan_in.region_end <= nxt.last;
                end else begin
                    scan_in.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_lookup_result want;
        if (!i_rst_n) begin
            scan_out.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (scan_out.valid && scan_out.ready) begin
                results_out++;
                if (lookup_expect_q.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: status %0d addr %h sector %h",
                                              scan_out.lookup_status, scan_out.found_address,
                                              scan_out.found_sector));
                end else begin
                    want = lookup_expect_q.pop_front();
                    if (scan_out.lookup_status !== want.status)
                        report_mismatch($sformatf("lookup_status %0d, want %0d",
                                                  scan_out.lookup_status, want.status));
                    if (scan_out.found_address !== want.addr)
                        report_mismatch($sformatf("found_address %h, want %h",
                                                  scan_out.found_address, want.addr));
                    if (scan_out.found_sector !== want.sector)
                        report_mismatch($sformatf("found_sector %h, want %h",
                                                  scan_out.found_sector, want.sector));
                    if (want.status == STATUS_FOUND)
                        found_out++;
                end
            end
            if (out_gap != 0) begin
                out_gap--;
                scan_out.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                out_gap = $urandom_range(0, 7);
                scan_out.ready <= 1'b0;
            end else begin
                scan_out.ready <= 1'b1;
            end
        end
    end

    initial begin : main
        int        r;
        logic [31:0] base;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_KEY0;
        i_cfg_data         = '0;
        scan_in.valid      = 1'b0;
        scan_in.table_byte = '0;
        scan_in.region_end = 1'b0;
        scan_out.ready     = 1'b0;
        for (r = 0; r < KEY_WORDS; r++)
            key_word[r] = '0;
        area_base = '0;
        restart_entry();
        scan_done = 1'b0;
        have_held = 1'b0;
        idle_on   = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero address, empty entry, top sector, bad form, open end, cut, ignored tail
        make_key(KEY_UUID);
        set_config(32'h0);
        load_key_entry();
        put_partial(ENTRY_BYTES, 16'h0000);
        close_region();
        put_byte(8'h00);
        close_region();
        put_others(1);
        load_key_entry();
        put_partial(ENTRY_BYTES, 16'hffff);
        close_region();
        load_key_entry();
        ent_txt[POS_HYPHEN1] = CH_0;
        put_partial(ENTRY_BYTES, 16'h0000);
        close_region();
        put_byte(8'hff);
        close_region();
        put_others(1);
        close_region();
        load_key_entry();
        put_partial(20, 16'h0000);
        close_region();
        load_key_entry();
        put_partial(ENTRY_BYTES, 16'h1234);
        put_noise(5);
        close_region();
        settle();

        // address wraps to zero, then all-ones base and key
        set_config(32'hffff_f000);
        load_key_entry();
        put_partial(ENTRY_BYTES, 16'h0001);
        close_region();
        load_key_entry();
        put_partial(ENTRY_BYTES, 16'hffff);
        close_region();
        settle();
        make_key(KEY_ONES);
        set_config(32'hffff_ffff);
        gen_region(RG_MATCH);
        gen_region(RG_NOISE);
        settle();

        while (beats_in < TARGET_BEATS || results_out < TARGET_RESULTS) begin
            r = $urandom_range(0, 9);
            make_key(r == 0 ? KEY_ONES : r == 1 ? KEY_ZERO : r == 2 ? KEY_NOISE : KEY_UUID);
            r = $urandom_range(0, 5);
            base = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom;
            set_config(base);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(6, 14)) gen_region(pick_kind());
            settle();
        end

        // closing stretch at full rate
        idle_on = 1'b0;
        make_key(KEY_UUID);
        set_config($urandom);
        repeat (10) gen_region(pick_kind());
        settle();

        if (lookup_expect_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", lookup_expect_q.size()));
        $display("run covered %0d table bytes in %0d regions under %0d key and base settings",
                 beats_in, regions_cnt, settings_cnt);
        $display("%0d lookup results checked, %0d of them found", results_out, found_out);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
